@@ src/address_breakpoint_unit_macros.svh @@
// Assertion macros shared by the breakpoint unit.
`ifndef ADDRESS_BREAKPOINT_UNIT_MACROS_SVH
`define ADDRESS_BREAKPOINT_UNIT_MACROS_SVH

// Same-cycle implication.
`define ABU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("address_breakpoint_unit: same-cycle check failed");

// Next-cycle implication.
`define ABU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("address_breakpoint_unit: next-cycle check failed");

`endif

@@ src/abu_pkg.sv @@
package abu_pkg;

   localparam int ADDR_W  = 64;
   localparam int MODE_W  = 3;
   localparam int SLOT_W  = 4;
   localparam int INDEX_W = 8;
   localparam int ENTRY_W = ADDR_W + MODE_W + 1;

   localparam logic [MODE_W-1:0] MODE_RW = 3'b011;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_BAD_IDX = 2'd2;

   typedef enum logic [1:0] {
      KIND_ACCESS = 2'd0,
      KIND_FINISH = 2'd1,
      KIND_ADD    = 2'd2,
      KIND_DELETE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_start;
      logic scan_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     ignore;
      logic     scan_hit;
      logic     scan_end;
      logic     out_free;
   } sts_type;

endpackage

@@ src/abu_ctrl.sv @@
module abu_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  abu_pkg::sts_type sts,
   output abu_pkg::cmd_type cmd
);

   abu_pkg::state_type state_ff;
   abu_pkg::state_type state_in;
   logic               scan_needed;

   assign scan_needed = (sts.kind == abu_pkg::KIND_ADD) ||
                        ((sts.kind == abu_pkg::KIND_ACCESS) && !sts.ignore);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= abu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         abu_pkg::ST_IDLE: begin
            if (req_valid) state_in = abu_pkg::ST_DECODE;
         end
         abu_pkg::ST_DECODE: begin
            state_in = scan_needed ? abu_pkg::ST_SCAN : abu_pkg::ST_WRITE;
         end
         abu_pkg::ST_SCAN: begin
            if (sts.scan_hit || sts.scan_end) state_in = abu_pkg::ST_WRITE;
         end
         abu_pkg::ST_WRITE: begin
            if (sts.out_free) state_in = abu_pkg::ST_IDLE;
         end
         default: state_in = abu_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready      = 1'b0;
      cmd.load       = 1'b0;
      cmd.scan_start = 1'b0;
      cmd.scan_step  = 1'b0;
      cmd.commit     = 1'b0;
      unique case (state_ff)
         abu_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         abu_pkg::ST_DECODE: begin
            cmd.scan_start = scan_needed;
         end
         abu_pkg::ST_SCAN: begin
            cmd.scan_step = !(sts.scan_hit || sts.scan_end);
         end
         abu_pkg::ST_WRITE: begin
            cmd.commit = sts.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

@@ src/abu_dp.sv @@
`include "address_breakpoint_unit_macros.svh"

module abu_dp #(
   parameter int NUM_ENTRIES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  abu_pkg::cmd_type              cmd,
   output abu_pkg::sts_type              sts,
   input  logic [1:0]                    req_kind,
   input  logic [abu_pkg::ADDR_W-1:0]    req_access_addr,
   input  logic [abu_pkg::ADDR_W-1:0]    req_access_phys_addr,
   input  logic [abu_pkg::MODE_W-1:0]    req_access_mode,
   input  logic                          req_access_is_save_unsave,
   input  logic [abu_pkg::ADDR_W-1:0]    req_bp_addr,
   input  logic [abu_pkg::MODE_W-1:0]    req_bp_mode,
   input  logic                          req_bp_physical,
   input  logic [abu_pkg::INDEX_W-1:0]   req_bp_index,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [abu_pkg::SLOT_W-1:0]    rsp_slot_index,
   output logic                          rsp_break_now,
   output logic                          rsp_break_is_physical,
   output logic [abu_pkg::ADDR_W-1:0]    rsp_break_addr,
   output logic                          rsp_pause_now
);

   localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

   // latched request
   abu_pkg::kind_type               kind_ff;
   logic [abu_pkg::ADDR_W-1:0]      vaddr_ff;
   logic [abu_pkg::ADDR_W-1:0]      paddr_ff;
   logic [abu_pkg::MODE_W-1:0]      amode_ff;
   logic                            save_ff;
   logic [abu_pkg::ADDR_W-1:0]      bp_addr_ff;
   logic [abu_pkg::MODE_W-1:0]      bp_mode_ff;
   logic                            bp_phys_ff;
   logic [abu_pkg::INDEX_W-1:0]     bp_index_ff;

   // table
   logic [abu_pkg::ENTRY_W-1:0]     mem [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0]          valid_ff;
   logic [NUM_ENTRIES-1:0]          valid_in;

   // scan pipeline
   logic [IDX_W-1:0]                ptr_ff;
   logic [IDX_W-1:0]                cmp_idx_ff;
   logic                            cmp_vld_ff;
   logic                            cmp_valid_bit_ff;
   logic [abu_pkg::ENTRY_W-1:0]     rd_entry_ff;

   // flags
   logic                            ignore_ff;
   logic                            ignore_in;
   logic                            pending_ff;
   logic                            pending_in;

   // output register
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [1:0]                      rsp_status_ff;
   logic [1:0]                      rsp_status_in;
   logic [abu_pkg::SLOT_W-1:0]      rsp_slot_ff;
   logic [abu_pkg::SLOT_W-1:0]      rsp_slot_in;
   logic                            rsp_break_now_ff;
   logic                            rsp_break_now_in;
   logic                            rsp_break_phys_ff;
   logic                            rsp_break_phys_in;
   logic [abu_pkg::ADDR_W-1:0]      rsp_break_addr_ff;
   logic [abu_pkg::ADDR_W-1:0]      rsp_break_addr_in;
   logic                            rsp_pause_now_ff;
   logic                            rsp_pause_now_in;

   logic                            ent_phys;
   logic [abu_pkg::MODE_W-1:0]      ent_mode;
   logic [abu_pkg::ADDR_W-1:0]      ent_addr;
   logic [abu_pkg::ADDR_W-1:0]      cmp_addr;
   logic                            access_match;
   logic                            scan_hit;
   logic                            scan_end;
   logic                            del_ok;
   logic                            delayed;
   logic [IDX_W+abu_pkg::SLOT_W-1:0] idx_ext;
   logic                            access_hit;
   logic                            pause_due;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff     <= abu_pkg::kind_type'(req_kind);
         vaddr_ff    <= req_access_addr;
         paddr_ff    <= req_access_phys_addr;
         amode_ff    <= req_access_mode;
         save_ff     <= req_access_is_save_unsave;
         bp_addr_ff  <= req_bp_addr;
         bp_mode_ff  <= req_bp_mode;
         bp_phys_ff  <= req_bp_physical;
         bp_index_ff <= req_bp_index;
      end
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.commit && (kind_ff == abu_pkg::KIND_ADD) && scan_hit) begin
         mem[cmp_idx_ff] <= {bp_phys_ff, bp_mode_ff, bp_addr_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step) begin
         rd_entry_ff      <= mem[ptr_ff];
         cmp_valid_bit_ff <= valid_ff[ptr_ff];
         cmp_idx_ff       <= ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         cmp_vld_ff <= 1'b0;
      end else if (cmd.load || cmd.scan_start) begin
         ptr_ff     <= '0;
         cmp_vld_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         ptr_ff     <= ptr_ff + 1'b1;
         cmp_vld_ff <= 1'b1;
      end
   end

   assign {ent_phys, ent_mode, ent_addr} = rd_entry_ff;
   assign cmp_addr     = ent_phys ? paddr_ff : vaddr_ff;
   assign access_match = cmp_valid_bit_ff && ((ent_mode & amode_ff) != '0) &&
                         (ent_addr == cmp_addr);
   assign scan_hit     = cmp_vld_ff && ((kind_ff == abu_pkg::KIND_ADD) ?
                                        !cmp_valid_bit_ff : access_match);
   assign scan_end     = cmp_vld_ff && !scan_hit &&
                         (cmp_idx_ff == IDX_W'(NUM_ENTRIES - 1));
   assign del_ok       = (bp_index_ff < abu_pkg::INDEX_W'(NUM_ENTRIES)) &&
                         valid_ff[bp_index_ff[IDX_W-1:0]];
   assign delayed      = ((amode_ff & abu_pkg::MODE_RW) != '0) && save_ff;
   assign idx_ext      = {{abu_pkg::SLOT_W{1'b0}}, cmp_idx_ff};

   always_comb begin
      valid_in = valid_ff;
      if (cmd.commit) begin
         if ((kind_ff == abu_pkg::KIND_ADD) && scan_hit) begin
            valid_in[cmp_idx_ff] = 1'b1;
         end else if ((kind_ff == abu_pkg::KIND_DELETE) && del_ok) begin
            valid_in[bp_index_ff[IDX_W-1:0]] = 1'b0;
         end
      end
   end

   always_comb begin
      ignore_in         = ignore_ff;
      pending_in        = pending_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_status_in     = rsp_status_ff;
      rsp_slot_in       = rsp_slot_ff;
      rsp_break_now_in  = rsp_break_now_ff;
      rsp_break_phys_in = rsp_break_phys_ff;
      rsp_break_addr_in = rsp_break_addr_ff;
      rsp_pause_now_in  = rsp_pause_now_ff;
      if (cmd.commit) begin
         rsp_valid_in      = 1'b1;
         rsp_status_in     = abu_pkg::STATUS_OK;
         rsp_slot_in       = '0;
         rsp_break_now_in  = 1'b0;
         rsp_break_phys_in = 1'b0;
         rsp_break_addr_in = '0;
         rsp_pause_now_in  = 1'b0;
         unique case (kind_ff)
            abu_pkg::KIND_ACCESS: begin
               if (!ignore_ff && scan_hit) begin
                  ignore_in         = 1'b1;
                  rsp_slot_in       = idx_ext[abu_pkg::SLOT_W-1:0];
                  rsp_break_phys_in = ent_phys;
                  rsp_break_addr_in = cmp_addr;
                  // SAVE/UNSAVE data accesses defer the break to instruction end
                  if (delayed) begin
                     pending_in = 1'b1;
                  end else begin
                     rsp_break_now_in = 1'b1;
                  end
               end
            end
            abu_pkg::KIND_FINISH: begin
               ignore_in        = 1'b0;
               pending_in       = 1'b0;
               rsp_pause_now_in = pending_ff;
            end
            abu_pkg::KIND_ADD: begin
               if (scan_hit) begin
                  rsp_slot_in = idx_ext[abu_pkg::SLOT_W-1:0];
               end else begin
                  rsp_status_in = abu_pkg::STATUS_FULL;
               end
            end
            abu_pkg::KIND_DELETE: begin
               if (!del_ok) rsp_status_in = abu_pkg::STATUS_BAD_IDX;
            end
            default: begin
               rsp_status_in = abu_pkg::STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         ignore_ff    <= 1'b0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         ignore_ff    <= ignore_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff     <= rsp_status_in;
      rsp_slot_ff       <= rsp_slot_in;
      rsp_break_now_ff  <= rsp_break_now_in;
      rsp_break_phys_ff <= rsp_break_phys_in;
      rsp_break_addr_ff <= rsp_break_addr_in;
      rsp_pause_now_ff  <= rsp_pause_now_in;
   end

   assign sts.kind     = kind_ff;
   assign sts.ignore   = ignore_ff;
   assign sts.scan_hit = scan_hit;
   assign sts.scan_end = scan_end;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_slot_index        = rsp_slot_ff;
   assign rsp_break_now         = rsp_break_now_ff;
   assign rsp_break_is_physical = rsp_break_phys_ff;
   assign rsp_break_addr        = rsp_break_addr_ff;
   assign rsp_pause_now         = rsp_pause_now_ff;

   assign access_hit = cmd.commit && (kind_ff == abu_pkg::KIND_ACCESS) && scan_hit;
   assign pause_due  = cmd.commit && (kind_ff == abu_pkg::KIND_FINISH) && pending_ff;

   `ABU_ASSERT_NOW(a_hit_end_excl, clock, reset, scan_hit, !scan_end)
   `ABU_ASSERT_NEXT(a_commit_fills_out, clock, reset, cmd.commit, rsp_valid_ff)
   `ABU_ASSERT_NEXT(a_break_sets_ignore, clock, reset, access_hit, ignore_ff)
   `ABU_ASSERT_NEXT(a_pause_due, clock, reset, pause_due, rsp_pause_now_ff && !pending_ff)

endmodule

@@ src/address_breakpoint_unit.sv @@
// Channel    | Direction | Handshake             | Moves
// -----------+-----------+-----------------------+----------------------------------
// req_*      | in        | req_valid / req_ready | one request: access/finish/add/del
// rsp_*      | out       | rsp_valid / rsp_ready | one result per request
//
// Access and add requests scan the table one slot per cycle through the single
// address comparator fed by the entry memory's registered read port; finish, delete
// and ignored accesses go from decode straight to the write step. Reset (synchronous)
// clears the valid bits, the ignore and pending flags and the handshake state; the
// entry memory is not cleared. A result waits in the output register, so a new
// request is taken while it is not yet read; a stalled result output holds the next
// request in its final step.
module address_breakpoint_unit #(
   parameter int NUM_ENTRIES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_kind,
   input  logic [abu_pkg::ADDR_W-1:0]    req_access_addr,
   input  logic [abu_pkg::ADDR_W-1:0]    req_access_phys_addr,
   input  logic [abu_pkg::MODE_W-1:0]    req_access_mode,
   input  logic                          req_access_is_save_unsave,
   input  logic [abu_pkg::ADDR_W-1:0]    req_bp_addr,
   input  logic [abu_pkg::MODE_W-1:0]    req_bp_mode,
   input  logic                          req_bp_physical,
   input  logic [abu_pkg::INDEX_W-1:0]   req_bp_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [abu_pkg::SLOT_W-1:0]    rsp_slot_index,
   output logic                          rsp_break_now,
   output logic                          rsp_break_is_physical,
   output logic [abu_pkg::ADDR_W-1:0]    rsp_break_addr,
   output logic                          rsp_pause_now
);

   // command and status between sequencer and datapath
   abu_pkg::cmd_type cmd;
   abu_pkg::sts_type sts;

   // sequencer: accept, decode, scan the table, commit the result
   abu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: request latch, entry table, comparator, flags, output register
   abu_dp #(
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_dp (
      .clock                     (clock),
      .reset                     (reset),
      .cmd                       (cmd),
      .sts                       (sts),
      .req_kind                  (req_kind),
      .req_access_addr           (req_access_addr),
      .req_access_phys_addr      (req_access_phys_addr),
      .req_access_mode           (req_access_mode),
      .req_access_is_save_unsave (req_access_is_save_unsave),
      .req_bp_addr               (req_bp_addr),
      .req_bp_mode               (req_bp_mode),
      .req_bp_physical           (req_bp_physical),
      .req_bp_index              (req_bp_index),
      .rsp_ready                 (rsp_ready),
      .rsp_valid                 (rsp_valid),
      .rsp_status                (rsp_status),
      .rsp_slot_index            (rsp_slot_index),
      .rsp_break_now             (rsp_break_now),
      .rsp_break_is_physical     (rsp_break_is_physical),
      .rsp_break_addr            (rsp_break_addr),
      .rsp_pause_now             (rsp_pause_now)
   );

endmodule

@@ bench/breakpoint_checker.sv @@
`timescale 1ns / 100ps

module breakpoint_checker #(
   parameter int SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [1:0]                    req_kind,
   input  logic [abu_pkg::ADDR_W-1:0]    req_access_addr,
   input  logic [abu_pkg::ADDR_W-1:0]    req_access_phys_addr,
   input  logic [abu_pkg::MODE_W-1:0]    req_access_mode,
   input  logic                          req_access_is_save_unsave,
   input  logic [abu_pkg::ADDR_W-1:0]    req_bp_addr,
   input  logic [abu_pkg::MODE_W-1:0]    req_bp_mode,
   input  logic                          req_bp_physical,
   input  logic [abu_pkg::INDEX_W-1:0]   req_bp_index,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [1:0]                    rsp_status,
   input  logic [abu_pkg::SLOT_W-1:0]    rsp_slot_index,
   input  logic                          rsp_break_now,
   input  logic                          rsp_break_is_physical,
   input  logic [abu_pkg::ADDR_W-1:0]    rsp_break_addr,
   input  logic                          rsp_pause_now,
   output int                            mismatches,
   output int                            outstanding
);

   typedef struct {
      logic [1:0]                 status;
      logic [abu_pkg::SLOT_W-1:0] slot;
      logic                       brk;
      logic                       phys;
      logic [abu_pkg::ADDR_W-1:0] addr;
      logic                       pause;
   } outcome_type;

   outcome_type awaited[$];

   // shadow breakpoint table and per-instruction flags
   logic                       slot_used [SLOTS];
   logic                       slot_phys [SLOTS];
   logic [abu_pkg::MODE_W-1:0] slot_mode [SLOTS];
   logic [abu_pkg::ADDR_W-1:0] slot_addr [SLOTS];
   logic                       ignoring;
   logic                       pause_owed;
   int                         errors = 0;

   // Apply the request on the channel to the shadow table; return its result.
   function automatic outcome_type evaluate_request();
      outcome_type                o;
      logic [abu_pkg::ADDR_W-1:0] cmp;
      bit                         found;
      int                         free_slot;
      o = '{status: abu_pkg::STATUS_OK, slot: '0, brk: 1'b0, phys: 1'b0, addr: '0,
            pause: 1'b0};
      case (abu_pkg::kind_type'(req_kind))
         abu_pkg::KIND_ACCESS: begin
            found = 1'b0;
            if (!ignoring) begin
               for (int i = 0; i < SLOTS; i++) begin
                  cmp = slot_phys[i] ? req_access_phys_addr : req_access_addr;
                  if (!found && slot_used[i] && (slot_mode[i] & req_access_mode) != '0
                      && slot_addr[i] == cmp) begin
                     found    = 1'b1;
                     ignoring = 1'b1;
                     o.slot   = abu_pkg::SLOT_W'(i);
                     o.phys   = slot_phys[i];
                     o.addr   = cmp;
                     if ((req_access_mode & abu_pkg::MODE_RW) != '0
                         && req_access_is_save_unsave)
                        pause_owed = 1'b1;
                     else
                        o.brk = 1'b1;
                  end
               end
            end
         end
         abu_pkg::KIND_FINISH: begin
            ignoring = 1'b0;
            if (pause_owed) begin
               pause_owed = 1'b0;
               o.pause    = 1'b1;
            end
         end
         abu_pkg::KIND_ADD: begin
            free_slot = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
               if (!slot_used[i]) free_slot = i;
            if (free_slot < 0) begin
               o.status = abu_pkg::STATUS_FULL;
            end else begin
               slot_used[free_slot] = 1'b1;
               slot_phys[free_slot] = req_bp_physical;
               slot_mode[free_slot] = req_bp_mode;
               slot_addr[free_slot] = req_bp_addr;
               o.slot               = abu_pkg::SLOT_W'(free_slot);
            end
         end
         default: begin
            if (int'(req_bp_index) >= SLOTS)
               o.status = abu_pkg::STATUS_BAD_IDX;
            else if (!slot_used[req_bp_index])
               o.status = abu_pkg::STATUS_BAD_IDX;
            else
               slot_used[req_bp_index] = 1'b0;
         end
      endcase
      return o;
   endfunction

   always @(posedge clock) begin : monitor
      outcome_type got;
      outcome_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_phys[i] = 1'b0;
            slot_mode[i] = '0;
            slot_addr[i] = '0;
         end
         ignoring   = 1'b0;
         pause_owed = 1'b0;
         awaited.delete();
      end else begin
         // a result leaving now belongs to an earlier request, so check it first
         if (rsp_valid && rsp_ready) begin
            got = '{status: rsp_status, slot: rsp_slot_index, brk: rsp_break_now,
                    phys: rsp_break_is_physical, addr: rsp_break_addr, pause: rsp_pause_now};
            if (awaited.size() == 0) begin
               if (errors < 10)
                  $display("%0t: result with no request outstanding: status=%0d slot=%0d",
                           $realtime, got.status, got.slot);
               errors++;
            end else begin
               want = awaited.pop_front();
               if (want.status !== got.status || want.slot !== got.slot
                   || want.brk !== got.brk || want.phys !== got.phys
                   || want.addr !== got.addr || want.pause !== got.pause) begin
                  if (errors < 10) begin
                     $display("%0t: expected status=%0d slot=%0d brk=%0b phys=%0b",
                              $realtime, want.status, want.slot, want.brk, want.phys);
                     $display("%0t:   expected addr=%h pause=%0b",
                              $realtime, want.addr, want.pause);
                     $display("%0t:   actual status=%0d slot=%0d brk=%0b phys=%0b",
                              $realtime, got.status, got.slot, got.brk, got.phys);
                     $display("%0t:   actual addr=%h pause=%0b",
                              $realtime, got.addr, got.pause);
                  end
                  errors++;
               end
            end
         end
         if (req_valid && req_ready)
            awaited.push_back(evaluate_request());
      end
      mismatches  <= errors;
      outstanding <= awaited.size();
   end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;

   localparam int SLOTS          = 16;
   localparam int PHASE_ONE_END  = 560;   // requests issued when each idling phase ends
   localparam int PHASE_TWO_END  = 1100;
   localparam int RUN_END        = 1625;
   localparam int EPISODE        = 80;    // requests per fill or drain episode of the table
   localparam int LONG_HOLD      = 400;   // receiver hold-off, in cycles
   localparam int WATCHDOG_LIMIT = 5000;  // cycles without any handshake
   localparam int DRAIN_CYCLES   = 60;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [1:0]                    req_kind = '0;
   logic [abu_pkg::ADDR_W-1:0]    req_access_addr = '0;
   logic [abu_pkg::ADDR_W-1:0]    req_access_phys_addr = '0;
   logic [abu_pkg::MODE_W-1:0]    req_access_mode = '0;
   logic                          req_access_is_save_unsave = 1'b0;
   logic [abu_pkg::ADDR_W-1:0]    req_bp_addr = '0;
   logic [abu_pkg::MODE_W-1:0]    req_bp_mode = '0;
   logic                          req_bp_physical = 1'b0;
   logic [abu_pkg::INDEX_W-1:0]   req_bp_index = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [1:0]                    rsp_status;
   logic [abu_pkg::SLOT_W-1:0]    rsp_slot_index;
   logic                          rsp_break_now;
   logic                          rsp_break_is_physical;
   logic [abu_pkg::ADDR_W-1:0]    rsp_break_addr;
   logic                          rsp_pause_now;
   int                            mismatches;
   int                            outstanding;

   int                            send_idle_pct = 0;
   int                            recv_idle_pct = 0;
   int                            issued = 0;
   int                            holds_asked = 0;
   int                            holds_served = 0;
   int                            hold_left = 0;
   int                            quiet_cycles = 0;
   logic [abu_pkg::ADDR_W-1:0]    addr_pool [8];

   address_breakpoint_unit #(.NUM_ENTRIES(SLOTS)) uut (.*);

   breakpoint_checker #(.SLOTS(SLOTS)) check (.*);

   // 4 ns clock: 2 ns high, 2 ns low
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver: drive ready at the falling edge; serve a long hold-off when asked.
   always @(negedge clock) begin
      if (holds_served != holds_asked) begin
         holds_served++;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   function automatic logic [abu_pkg::ADDR_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [abu_pkg::MODE_W-1:0] random_mode();
      return abu_pkg::MODE_W'($urandom_range(7));
   endfunction

   function automatic logic random_bit();
      return 1'($urandom_range(1));
   endfunction

   function automatic logic [abu_pkg::INDEX_W-1:0] random_index();
      return abu_pkg::INDEX_W'($urandom_range(255));
   endfunction

   // Take an address from the shared pool pct percent of the time, so that
   // accesses hit breakpoints often; otherwise a fresh random address.
   function automatic logic [abu_pkg::ADDR_W-1:0] pick_addr(input int pct);
      if ($urandom_range(99) < pct)
         return addr_pool[3'($urandom_range(7))];
      return random_word();
   endfunction

   // Offer one request: idle for a random gap, then hold valid and payload
   // until the request is accepted.
   task automatic send_request(input logic [1:0] kind,
                               input logic [abu_pkg::ADDR_W-1:0] va,
                               input logic [abu_pkg::ADDR_W-1:0] pa,
                               input logic [abu_pkg::MODE_W-1:0] am,
                               input logic su,
                               input logic [abu_pkg::ADDR_W-1:0] ba,
                               input logic [abu_pkg::MODE_W-1:0] bm,
                               input logic bp,
                               input logic [abu_pkg::INDEX_W-1:0] bi);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_kind                  = kind;
      req_access_addr           = va;
      req_access_phys_addr      = pa;
      req_access_mode           = am;
      req_access_is_save_unsave = su;
      req_bp_addr               = ba;
      req_bp_mode               = bm;
      req_bp_physical           = bp;
      req_bp_index              = bi;
      req_valid                 = 1'b1;
      do @(posedge clock); while (!req_ready);
      issued++;
   endtask

   // The wrappers fill the fields a request does not use with random bits.
   task automatic send_access(input logic [abu_pkg::ADDR_W-1:0] va,
                              input logic [abu_pkg::ADDR_W-1:0] pa,
                              input logic [abu_pkg::MODE_W-1:0] am, input logic su);
      send_request(abu_pkg::KIND_ACCESS, va, pa, am, su, random_word(), random_mode(),
                   random_bit(), random_index());
   endtask

   task automatic send_finish();
      send_request(abu_pkg::KIND_FINISH, random_word(), random_word(), random_mode(),
                   random_bit(), random_word(), random_mode(), random_bit(),
                   random_index());
   endtask

   task automatic send_add(input logic [abu_pkg::ADDR_W-1:0] ba,
                           input logic [abu_pkg::MODE_W-1:0] bm, input logic bp);
      send_request(abu_pkg::KIND_ADD, random_word(), random_word(), random_mode(),
                   random_bit(), ba, bm, bp, random_index());
   endtask

   task automatic send_delete(input logic [abu_pkg::INDEX_W-1:0] bi);
      send_request(abu_pkg::KIND_DELETE, random_word(), random_word(), random_mode(),
                   random_bit(), random_word(), random_mode(), random_bit(), bi);
   endtask

   task automatic run_directed();
      // empty table: finish with nothing pending, access with no match, bad deletes
      send_finish();
      send_access('0, '0, 3'b111, 1'b0);
      send_delete(8'd0);
      send_delete(8'(SLOTS));
      send_delete(8'hff);
      // slot 0 virtual all modes, slot 1 physical execute, slot 2 empty mask,
      // slot 3 physical write
      send_add('0, 3'b111, 1'b0);
      send_add('1, 3'b100, 1'b1);
      send_add(addr_pool[2], 3'b000, 1'b0);
      send_add(addr_pool[3], 3'b010, 1'b1);
      // plain break, then an ignored access in the same instruction
      send_access('0, addr_pool[5], 3'b001, 1'b0);
      send_access('0, addr_pool[5], 3'b111, 1'b0);
      send_finish();
      // physical match on the all-ones address
      send_access(addr_pool[4], '1, 3'b100, 1'b0);
      send_finish();
      // entry with an empty mask never matches
      send_access(addr_pool[2], addr_pool[5], 3'b111, 1'b0);
      // SAVE/UNSAVE read: break delayed, reported as a pause at the finish
      send_access('0, addr_pool[5], 3'b001, 1'b1);
      send_access('0, addr_pool[5], 3'b001, 1'b0);
      send_finish();
      // SAVE/UNSAVE execute is raised at once
      send_access(addr_pool[4], '1, 3'b100, 1'b1);
      send_finish();
      // SAVE/UNSAVE write on a physical entry
      send_access(addr_pool[6], addr_pool[3], 3'b010, 1'b1);
      send_finish();
      // delete, then add refills the lowest free slot; delete of an empty slot
      send_delete(8'd1);
      send_add(addr_pool[7], 3'b001, 1'b0);
      send_delete(8'(SLOTS - 1));
   endtask

   // One random step: mostly instructions (a few accesses and a finish), some
   // table management, and some noise. The finish is dropped now and then.
   task automatic issue_random(input bit filling);
      int roll;
      int n;
      roll = $urandom_range(99);
      if (roll < 8) begin
         send_request(2'($urandom_range(3)), random_word(), random_word(), random_mode(),
                      random_bit(), random_word(), random_mode(), random_bit(),
                      random_index());
      end else if (roll < 43) begin
         if ($urandom_range(99) < (filling ? 90 : 15))
            send_add(pick_addr(85), random_mode(), random_bit());
         else if ($urandom_range(99) < 80)
            send_delete(abu_pkg::INDEX_W'($urandom_range(SLOTS - 1)));
         else
            send_delete(abu_pkg::INDEX_W'($urandom_range(255, SLOTS)));
      end else begin
         n = $urandom_range(4, 1);
         repeat (n)
            send_access(pick_addr(70), pick_addr(70), random_mode(),
                        $urandom_range(99) < 25);
         if ($urandom_range(9) != 0)
            send_finish();
      end
   endtask

   initial begin
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 2; i < 8; i++)
         addr_pool[i] = random_word();

      // hold reset, then release it at a falling edge
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // phase one: sender idles lightly, receiver heavily
      send_idle_pct = 35;
      recv_idle_pct = 88;
      run_directed();
      while (issued < PHASE_ONE_END)
         issue_random(((issued / EPISODE) % 2) == 0);

      // phase two: the other way round
      send_idle_pct = 88;
      recv_idle_pct = 35;
      while (issued < PHASE_TWO_END)
         issue_random(((issued / EPISODE) % 2) == 0);

      // phase three: no idling; start with a long receiver hold-off so the
      // block fills up and stalls its request input
      send_idle_pct = 0;
      recv_idle_pct = 0;
      holds_asked++;
      while (issued < RUN_END)
         issue_random(((issued / EPISODE) % 2) == 0);

      // drop valid, wait for every result, then let the block settle
      @(negedge clock);
      req_valid = 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0 && outstanding == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
